### rtl/grvr_pkg.sv
// Shared constants, types and state codes for the gravity-removed vibration RMS block.
`default_nettype none
package grvr_pkg;
	localparam int SAMPLE_WIDTH = 16;
	localparam int WINDOW_DEPTH = 32;
	localparam int FRAC_W       = 16;
	localparam int WEIGHT_W     = 16;
	localparam int LTIME_W      = 16;
	localparam int TIME_W       = 32;
	localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);
	localparam int GRAV_W       = SAMPLE_WIDTH + FRAC_W;
	localparam int PROD_W       = GRAV_W + 1 + WEIGHT_W + 1;
	localparam int VIB_W        = SAMPLE_WIDTH + 1;
	localparam int MAG_W        = SAMPLE_WIDTH + 1;
	localparam int SQ_W         = 2 * MAG_W + 2;
	localparam int SUM_W        = SQ_W + WIN_AW;
	localparam int ROOT_W       = SQ_W / 2;
	localparam int RMS_W        = 17;
	localparam int CNT_W        = $clog2((WEIGHT_W > MAG_W ? WEIGHT_W : MAG_W) + 1);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;

	localparam logic [LTIME_W-1:0]  LEARN_TIME_RST  = 16'd2000;
	localparam logic [WEIGHT_W-1:0] FAST_WEIGHT_RST = 16'd6554;
	localparam logic [WEIGHT_W-1:0] SLOW_WEIGHT_RST = 16'd3277;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEARN_TIME  = 2'd0,
		REG_FAST_WEIGHT = 2'd1,
		REG_SLOW_WEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL,
		ST_GRAV,
		ST_VIB,
		ST_SQ,
		ST_WIN,
		ST_DIVGO,
		ST_ROOT,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

### rtl/grvr_if.sv
// Handshake channel interfaces: sample input, result output and register writes.
`default_nettype none
interface grvr_sample_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [grvr_pkg::SAMPLE_WIDTH-1:0] accel_x;
	logic signed [grvr_pkg::SAMPLE_WIDTH-1:0] accel_y;
	logic signed [grvr_pkg::SAMPLE_WIDTH-1:0] accel_z;
	logic                                    sensor_ready;
	logic [grvr_pkg::TIME_W-1:0]             now_ms;
	modport source (output valid, accel_x, accel_y, accel_z, sensor_ready, now_ms, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, sensor_ready, now_ms, output ready);
endinterface

interface grvr_result_if;
	logic                              valid;
	logic                              ready;
	logic [grvr_pkg::RMS_W-1:0]        rms_level;
	logic                              is_ready;
	logic signed [grvr_pkg::VIB_W-1:0] vib_x;
	logic signed [grvr_pkg::VIB_W-1:0] vib_y;
	logic signed [grvr_pkg::VIB_W-1:0] vib_z;
	modport source (output valid, rms_level, is_ready, vib_x, vib_y, vib_z, input ready);
	modport sink (input valid, rms_level, is_ready, vib_x, vib_y, vib_z, output ready);
endinterface

interface grvr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [grvr_pkg::CFG_IDX_W-1:0]   index;
	logic [grvr_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/grvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module grvr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/grvr_divsqrt.sv
// Bit-serial mean and integer square root: window sum / fill count, then floor sqrt.
`default_nettype none
module grvr_divsqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [grvr_pkg::SUM_W-1:0]    dividend,
	input  wire logic [grvr_pkg::FILL_W-1:0]   divisor,
	output logic                               done,
	output logic      [grvr_pkg::RMS_W-1:0]    root
);
	localparam int DCNT_W = $clog2(grvr_pkg::SUM_W + 1);
	localparam int RREM_W = grvr_pkg::ROOT_W + 2;

	logic                           div_busy_q;
	logic                           sqrt_busy_q;
	logic                           done_q;
	logic [DCNT_W-1:0]              cnt_q;
	logic [grvr_pkg::SUM_W-1:0]     num_q;
	logic [grvr_pkg::FILL_W-1:0]    den_q;
	logic [grvr_pkg::FILL_W-1:0]    rem_q;
	logic [grvr_pkg::SQ_W-1:0]      rad_q;
	logic [RREM_W-1:0]              rrem_q;
	logic [grvr_pkg::ROOT_W-1:0]    root_q;

	logic [grvr_pkg::FILL_W:0]      rem_sh;
	logic                           div_ge;
	logic [RREM_W-1:0]              rr;
	logic [RREM_W-1:0]              trial;
	logic                           sq_ge;

	always_comb begin
		rem_sh = {rem_q, num_q[grvr_pkg::SUM_W-1]};
		div_ge = rem_sh >= {1'b0, den_q};
		rr     = {rrem_q[RREM_W-3:0], rad_q[grvr_pkg::SQ_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		sq_ge  = rr >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q  <= 1'b0;
			sqrt_busy_q <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				div_busy_q <= 1'b1;
				cnt_q      <= '0;
			end else if (div_busy_q) begin
				if (cnt_q == DCNT_W'(grvr_pkg::SUM_W - 1)) begin
					div_busy_q  <= 1'b0;
					sqrt_busy_q <= 1'b1;
					cnt_q       <= '0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (sqrt_busy_q) begin
				if (cnt_q == DCNT_W'(grvr_pkg::ROOT_W - 1)) begin
					sqrt_busy_q <= 1'b0;
					done_q      <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// Restoring divide one quotient bit a cycle, then two radicand bits a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			rem_q  <= '0;
		end else if (div_busy_q) begin
			rem_q <= div_ge ? grvr_pkg::FILL_W'(rem_sh - {1'b0, den_q})
			                : grvr_pkg::FILL_W'(rem_sh);
			num_q <= {num_q[grvr_pkg::SUM_W-2:0], div_ge};
			if (cnt_q == DCNT_W'(grvr_pkg::SUM_W - 1)) begin
				rad_q  <= {num_q[grvr_pkg::SQ_W-2:0], div_ge};
				rrem_q <= '0;
				root_q <= '0;
			end
		end else if (sqrt_busy_q) begin
			rad_q  <= rad_q << 2;
			rrem_q <= sq_ge ? rr - trial : rr;
			root_q <= {root_q[grvr_pkg::ROOT_W-2:0], sq_ge};
		end
	end

	assign done = done_q;
	assign root = root_q[grvr_pkg::RMS_W-1:0];
endmodule
`default_nettype wire

### rtl/gravity_removed_vibration_rms.sv
// Top level: gravity estimate, vibration vector, sliding window and RMS result.
// Each sample runs through a shift-add gravity update (one weight bit per cycle,
// three axes side by side), a shift-add square of the vibration magnitudes,
// bit-serial division of the window sum by the fill count and a square root.
// Samples taken while calibrating skip the square, window and root steps, and
// samples with sensor_ready low skip all of the arithmetic. The next sample
// is taken once the previous one is done, while its result may still wait on
// the output register. The 32-entry window lives in a RAM and is emptied
// through the fill count, so no clearing pass runs.
`default_nettype none
module gravity_removed_vibration_rms (
	input  wire logic      clk,
	input  wire logic      arst_n,
	grvr_sample_if.sink    sample,
	grvr_result_if.source  result,
	grvr_cfg_if.sink       cfg
);
	localparam logic [grvr_pkg::PROD_W-1:0] ROUND_P = grvr_pkg::PROD_W'(1 << (grvr_pkg::FRAC_W - 1));
	localparam logic [grvr_pkg::GRAV_W:0]   ROUND_G = (grvr_pkg::GRAV_W + 1)'(1 << (grvr_pkg::FRAC_W - 1));

	grvr_pkg::state_t state_q, state_d;

	logic [grvr_pkg::LTIME_W-1:0]  ltime_q;
	logic [grvr_pkg::WEIGHT_W-1:0] fast_w_q;
	logic [grvr_pkg::WEIGHT_W-1:0] slow_w_q;

	logic                                 mode_q;
	logic                                 seeded_q;
	logic [grvr_pkg::TIME_W-1:0]          start_q;
	logic signed [grvr_pkg::GRAV_W-1:0]   g_q [3];
	logic signed [grvr_pkg::SAMPLE_WIDTH-1:0] a_q [3];
	logic                                 sready_q;
	logic [grvr_pkg::TIME_W-1:0]          now_q;

	logic signed [grvr_pkg::PROD_W-1:0]   d_q [3];
	logic signed [grvr_pkg::PROD_W-1:0]   acc_q [3];
	logic [grvr_pkg::WEIGHT_W-1:0]        w_q;
	logic [grvr_pkg::CNT_W-1:0]           cnt_q;

	logic signed [grvr_pkg::VIB_W-1:0]    vib_q [3];
	logic [grvr_pkg::SQ_W-1:0]            msh_q [3];
	logic [grvr_pkg::MAG_W-1:0]           mbit_q [3];
	logic [grvr_pkg::SQ_W-1:0]            sq_q;
	logic [grvr_pkg::RMS_W-1:0]           rms_q;

	logic [grvr_pkg::SUM_W-1:0]           sum_q;
	logic [grvr_pkg::WIN_AW-1:0]          pos_q;
	logic [grvr_pkg::FILL_W-1:0]          fill_q;

	logic                                 res_valid_q;
	logic [grvr_pkg::RMS_W-1:0]           res_rms_q;
	logic                                 res_ready_q;
	logic signed [grvr_pkg::VIB_W-1:0]    res_vib_q [3];

	logic                                 in_ready;
	logic                                 ram_we;
	logic                                 ds_start;
	logic                                 out_load;
	logic [grvr_pkg::SQ_W-1:0]            old_sq;
	logic [grvr_pkg::SQ_W-1:0]            ram_rdata;
	logic                                 ds_done;
	logic [grvr_pkg::RMS_W-1:0]           ds_root;
	logic                                 learn_done;
	logic signed [grvr_pkg::PROD_W-1:0]   a_ext [3];
	logic signed [grvr_pkg::PROD_W-1:0]   acc_rnd [3];
	logic signed [grvr_pkg::GRAV_W:0]     g_rnd [3];
	logic signed [grvr_pkg::VIB_W-1:0]    v_new [3];
	logic [grvr_pkg::SQ_W-1:0]            sq_add;

	grvr_ram #(
		.WIDTH(grvr_pkg::SQ_W),
		.DEPTH(grvr_pkg::WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(sq_q),
		.raddr(pos_q),
		.rdata(ram_rdata)
	);

	grvr_divsqrt u_divsqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ds_start),
		.dividend(sum_q),
		.divisor (fill_q),
		.done    (ds_done),
		.root    (ds_root)
	);

	always_comb begin
		learn_done = (now_q - start_q) >= grvr_pkg::TIME_W'(ltime_q);
		old_sq     = (fill_q == grvr_pkg::FILL_W'(grvr_pkg::WINDOW_DEPTH)) ? ram_rdata : '0;
		sq_add     = '0;
		for (int i = 0; i < 3; i++) begin
			a_ext[i]   = grvr_pkg::PROD_W'(signed'({a_q[i], grvr_pkg::FRAC_W'(0)}));
			acc_rnd[i] = (acc_q[i] + ROUND_P) >>> grvr_pkg::FRAC_W;
			g_rnd[i]   = ((grvr_pkg::GRAV_W + 1)'(g_q[i]) + ROUND_G) >>> grvr_pkg::FRAC_W;
			v_new[i]   = grvr_pkg::VIB_W'(a_q[i]) - g_rnd[i][grvr_pkg::VIB_W-1:0];
			sq_add     = sq_add + (mbit_q[i][0] ? msh_q[i] : '0);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			grvr_pkg::ST_IDLE:  if (sample.valid) state_d = grvr_pkg::ST_LOAD;
			grvr_pkg::ST_LOAD:  state_d = sready_q ? grvr_pkg::ST_MUL : grvr_pkg::ST_OUT;
			grvr_pkg::ST_MUL: begin
				if (cnt_q == grvr_pkg::CNT_W'(grvr_pkg::WEIGHT_W - 1)) state_d = grvr_pkg::ST_GRAV;
			end
			grvr_pkg::ST_GRAV:  state_d = grvr_pkg::ST_VIB;
			grvr_pkg::ST_VIB:   state_d = mode_q ? grvr_pkg::ST_SQ : grvr_pkg::ST_OUT;
			grvr_pkg::ST_SQ: begin
				if (cnt_q == grvr_pkg::CNT_W'(grvr_pkg::MAG_W - 1)) state_d = grvr_pkg::ST_WIN;
			end
			grvr_pkg::ST_WIN:   state_d = grvr_pkg::ST_DIVGO;
			grvr_pkg::ST_DIVGO: state_d = grvr_pkg::ST_ROOT;
			grvr_pkg::ST_ROOT:  if (ds_done) state_d = grvr_pkg::ST_OUT;
			grvr_pkg::ST_OUT:   if (!res_valid_q || result.ready) state_d = grvr_pkg::ST_IDLE;
			default:            state_d = grvr_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		ram_we   = 1'b0;
		ds_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			grvr_pkg::ST_IDLE:  in_ready = 1'b1;
			grvr_pkg::ST_WIN:   ram_we = 1'b1;
			grvr_pkg::ST_DIVGO: ds_start = 1'b1;
			grvr_pkg::ST_OUT:   out_load = !res_valid_q || result.ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= grvr_pkg::ST_IDLE;
			ltime_q     <= grvr_pkg::LEARN_TIME_RST;
			fast_w_q    <= grvr_pkg::FAST_WEIGHT_RST;
			slow_w_q    <= grvr_pkg::SLOW_WEIGHT_RST;
			mode_q      <= 1'b0;
			seeded_q    <= 1'b0;
			start_q     <= '0;
			sum_q       <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				g_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.index)
					grvr_pkg::REG_LEARN_TIME:  ltime_q  <= cfg.data;
					grvr_pkg::REG_FAST_WEIGHT: fast_w_q <= cfg.data;
					grvr_pkg::REG_SLOW_WEIGHT: slow_w_q <= cfg.data;
					default:                   ltime_q  <= ltime_q;
				endcase
			end
			// seed gravity from the first accepted sample with sensor_ready high
			if (in_ready && sample.valid && sample.sensor_ready && !seeded_q) begin
				seeded_q <= 1'b1;
				start_q  <= sample.now_ms;
				mode_q   <= 1'b0;
				g_q[0]   <= signed'({sample.accel_x, grvr_pkg::FRAC_W'(0)});
				g_q[1]   <= signed'({sample.accel_y, grvr_pkg::FRAC_W'(0)});
				g_q[2]   <= signed'({sample.accel_z, grvr_pkg::FRAC_W'(0)});
			end
			if (state_q == grvr_pkg::ST_LOAD && !sready_q) begin
				mode_q <= 1'b0;
				sum_q  <= '0;
				pos_q  <= '0;
				fill_q <= '0;
			end
			if (state_q == grvr_pkg::ST_GRAV) begin
				for (int i = 0; i < 3; i++) begin
					g_q[i] <= g_q[i] + acc_rnd[i][grvr_pkg::GRAV_W-1:0];
				end
			end
			if (state_q == grvr_pkg::ST_VIB && !mode_q) begin
				mode_q <= learn_done;
				sum_q  <= '0;
				pos_q  <= '0;
				fill_q <= '0;
			end
			if (state_q == grvr_pkg::ST_WIN) begin
				sum_q <= sum_q - grvr_pkg::SUM_W'(old_sq) + grvr_pkg::SUM_W'(sq_q);
				pos_q <= (pos_q == grvr_pkg::WIN_AW'(grvr_pkg::WINDOW_DEPTH - 1))
				         ? '0 : pos_q + 1'b1;
				if (fill_q != grvr_pkg::FILL_W'(grvr_pkg::WINDOW_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_ready && sample.valid) begin
			a_q[0]   <= sample.accel_x;
			a_q[1]   <= sample.accel_y;
			a_q[2]   <= sample.accel_z;
			sready_q <= sample.sensor_ready;
			now_q    <= sample.now_ms;
		end
		case (state_q)
			grvr_pkg::ST_LOAD: begin
				w_q   <= mode_q ? slow_w_q : fast_w_q;
				cnt_q <= '0;
				rms_q <= '0;
				for (int i = 0; i < 3; i++) begin
					d_q[i]   <= a_ext[i] - grvr_pkg::PROD_W'(g_q[i]);
					acc_q[i] <= '0;
					vib_q[i] <= '0;
				end
			end
			grvr_pkg::ST_MUL: begin
				w_q   <= w_q >> 1;
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < 3; i++) begin
					acc_q[i] <= acc_q[i] + (w_q[0] ? d_q[i] : '0);
					d_q[i]   <= d_q[i] <<< 1;
				end
			end
			grvr_pkg::ST_VIB: begin
				cnt_q <= '0;
				sq_q  <= '0;
				for (int i = 0; i < 3; i++) begin
					if (mode_q) begin
						vib_q[i]  <= v_new[i];
						mbit_q[i] <= v_new[i][grvr_pkg::VIB_W-1] ? grvr_pkg::MAG_W'(-v_new[i])
						                                         : grvr_pkg::MAG_W'(v_new[i]);
						msh_q[i]  <= v_new[i][grvr_pkg::VIB_W-1] ? grvr_pkg::SQ_W'(
						             grvr_pkg::MAG_W'(-v_new[i])) : grvr_pkg::SQ_W'(
						             grvr_pkg::MAG_W'(v_new[i]));
					end
				end
			end
			grvr_pkg::ST_SQ: begin
				cnt_q <= cnt_q + 1'b1;
				sq_q  <= sq_q + sq_add;
				for (int i = 0; i < 3; i++) begin
					msh_q[i]  <= msh_q[i] << 1;
					mbit_q[i] <= mbit_q[i] >> 1;
				end
			end
			grvr_pkg::ST_ROOT: begin
				if (ds_done) rms_q <= ds_root;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (out_load) begin
			res_rms_q   <= rms_q;
			res_ready_q <= mode_q;
			for (int i = 0; i < 3; i++) begin
				res_vib_q[i] <= vib_q[i];
			end
		end
	end

	assign sample.ready     = in_ready;
	assign cfg.ready        = 1'b1;
	assign result.valid     = res_valid_q;
	assign result.rms_level = res_rms_q;
	assign result.is_ready  = res_ready_q;
	assign result.vib_x     = res_vib_q[0];
	assign result.vib_y     = res_vib_q[1];
	assign result.vib_z     = res_vib_q[2];
endmodule
`default_nettype wire
